// ===== sv/rcsnr_pkg.sv =====
package rcsnr_pkg;

	localparam int RAND_W  = 31;
	localparam int CFG_W   = 13;
	localparam int COORD_W = 12;
	localparam int CIDX_W  = 2;
	localparam int STEP_W  = 5;

	localparam logic [CIDX_W-1:0] CFG_GRID_ROWS = 2'd0;
	localparam logic [CIDX_W-1:0] CFG_GRID_COLS = 2'd1;

	localparam logic REQ_FLIP  = 1'b0;
	localparam logic REQ_RESET = 1'b1;

	typedef struct packed {
		logic              req_type;
		logic [RAND_W-1:0] rand_value;
	} in_item_t;

	typedef struct packed {
		logic [COORD_W-1:0] row_index;
		logic [COORD_W-1:0] col_index;
		logic               exhausted;
	} out_item_t;

	typedef struct packed {
		logic              start;
		logic [STEP_W-1:0] steps;
	} div_req_t;

	typedef struct packed {
		logic done;
	} div_rsp_t;

endpackage

// ===== sv/rcsnr_div.sv =====
module rcsnr_div #(
	parameter int DVS_W = 13
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  rcsnr_pkg::div_req_t             ctl,
	input  logic [rcsnr_pkg::RAND_W-1:0]    dividend,
	input  logic [DVS_W-1:0]                divisor,
	output rcsnr_pkg::div_rsp_t             stat,
	output logic [rcsnr_pkg::RAND_W-1:0]    quotient,
	output logic [DVS_W-1:0]                remainder
);

	localparam int DVD_W = rcsnr_pkg::RAND_W;

	logic [DVD_W-1:0]             dq_q;
	logic [DVS_W-1:0]             rem_q;
	logic [DVS_W-1:0]             divisor_q;
	logic [rcsnr_pkg::STEP_W-1:0] cnt_q;
	logic                         run_q;
	logic                         done_q;

	logic [DVS_W:0]   trial;
	logic             take;
	logic [DVS_W-1:0] rem_next;

	// restoring step: shift in the next dividend bit, subtract if it fits
	always_comb begin
		trial    = {rem_q, dq_q[DVD_W-1]};
		take     = (trial >= {1'b0, divisor_q});
		rem_next = take ? DVS_W'(trial - {1'b0, divisor_q}) : trial[DVS_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				run_q <= 1'b1;
				cnt_q <= ctl.steps;
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == rcsnr_pkg::STEP_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			dq_q      <= dividend;
			rem_q     <= '0;
			divisor_q <= divisor;
		end else if (run_q) begin
			dq_q  <= {dq_q[DVD_W-2:0], take};
			rem_q <= rem_next;
		end
	end

	assign stat.done = done_q;
	assign quotient  = dq_q;
	assign remainder = rem_q;

endmodule

// ===== sv/random_cell_sampler_no_repeat_unit.sv =====
// flip: the grid product is formed and checked, 31 modulo steps reduce the random value by the
// free count to pick a table entry, which is read and swapped into the used part, then one split
// step per table index bit (12 at MAX_CELLS 4096) gives row and col; exhausted: done at the check
// reset item: clears the used count, no result; one item in work at a time, busy while working
// results appear on done for one cycle and cannot be held off
// after arst_n the table is swept back to the identity, one entry a cycle, with busy high;
// config writes are taken throughout
module random_cell_sampler_no_repeat_unit #(
	parameter int MAX_CELLS = 4096
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  rcsnr_pkg::in_item_t              item,
	output logic                             done,
	output rcsnr_pkg::out_item_t             result,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [rcsnr_pkg::CIDX_W-1:0]     cfg_index,
	input  logic [rcsnr_pkg::CFG_W-1:0]      cfg_data
);

	localparam int RAND_W  = rcsnr_pkg::RAND_W;
	localparam int CFG_W   = rcsnr_pkg::CFG_W;
	localparam int COORD_W = rcsnr_pkg::COORD_W;
	localparam int STEP_W  = rcsnr_pkg::STEP_W;
	localparam int IDX_W   = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
	localparam int CNT_W   = $clog2(MAX_CELLS + 1);
	localparam int DVS_W   = (CNT_W > CFG_W) ? CNT_W : CFG_W;
	localparam int PROD_W  = 2 * CFG_W;
	localparam int CELL_SH = RAND_W - IDX_W;

	typedef enum logic [8:0] {
		S_CLEAR = 9'b000000001,
		S_IDLE  = 9'b000000010,
		S_MUL   = 9'b000000100,
		S_CHECK = 9'b000001000,
		S_MOD   = 9'b000010000,
		S_RD    = 9'b000100000,
		S_SWAP1 = 9'b001000000,
		S_SWAP2 = 9'b010000000,
		S_DIV   = 9'b100000000
	} state_t;

	state_t state_q;

	logic [CFG_W-1:0]  rows_q;
	logic [CFG_W-1:0]  cols_q;
	logic [CNT_W-1:0]  used_q;
	logic [IDX_W-1:0]  clr_q;
	logic [PROD_W-1:0] prod_q;
	logic [RAND_W-1:0] rnd_q;
	logic [IDX_W-1:0]  pick_q;
	logic [IDX_W-1:0]  rd_a_q;
	logic [IDX_W-1:0]  rd_b_q;
	logic              done_q;
	rcsnr_pkg::out_item_t result_q;

	logic [IDX_W-1:0] mem [MAX_CELLS];

	logic [CNT_W-1:0]  total;
	logic [CNT_W-1:0]  remaining;
	logic              no_cell;
	logic [IDX_W-1:0]  used_idx;

	logic              mem_we;
	logic [IDX_W-1:0]  mem_waddr;
	logic [IDX_W-1:0]  mem_wdata;

	rcsnr_pkg::div_req_t div_ctl;
	rcsnr_pkg::div_rsp_t div_stat;
	logic [RAND_W-1:0]   div_dividend;
	logic [DVS_W-1:0]    div_divisor;
	logic [RAND_W-1:0]   div_quot;
	logic [DVS_W-1:0]    div_rem;

	assign cfg_ready = 1'b1;
	assign busy      = (state_q != S_IDLE);
	assign done      = done_q;
	assign result    = result_q;
	assign used_idx  = used_q[IDX_W-1:0];

	// grid larger than the table saturates
	always_comb begin
		total     = (prod_q > PROD_W'(MAX_CELLS)) ? CNT_W'(MAX_CELLS) : CNT_W'(prod_q);
		no_cell   = (used_q >= total) || (cols_q == '0);
		remaining = total - used_q;
	end

	always_comb begin
		div_ctl.start = 1'b0;
		div_ctl.steps = STEP_W'(RAND_W);
		div_dividend  = rnd_q;
		div_divisor   = DVS_W'(remaining);
		case (state_q)
			S_CHECK: begin
				div_ctl.start = !no_cell;
			end
			S_SWAP1: begin
				div_ctl.start = 1'b1;
				div_ctl.steps = STEP_W'(IDX_W);
				div_dividend  = RAND_W'(rd_b_q) << CELL_SH;
				div_divisor   = DVS_W'(cols_q);
			end
			default: begin
			end
		endcase
	end

	rcsnr_div #(
		.DVS_W(DVS_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (div_ctl),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.stat     (div_stat),
		.quotient (div_quot),
		.remainder(div_rem)
	);

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = used_idx;
		mem_wdata = rd_b_q;
		case (state_q)
			S_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = clr_q;
			end
			S_SWAP1: begin
				mem_we = 1'b1;
			end
			S_SWAP2: begin
				mem_we    = 1'b1;
				mem_waddr = pick_q;
				mem_wdata = rd_a_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (state_q == S_RD) begin
			rd_a_q <= mem[used_idx];
			rd_b_q <= mem[pick_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= CFG_W'(1);
			cols_q <= CFG_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				rcsnr_pkg::CFG_GRID_ROWS: rows_q <= cfg_data;
				rcsnr_pkg::CFG_GRID_COLS: cols_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			used_q  <= '0;
			clr_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == IDX_W'(MAX_CELLS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						if (item.req_type == rcsnr_pkg::REQ_RESET) begin
							used_q <= '0;
						end else begin
							state_q <= S_MUL;
						end
					end
				end
				S_MUL: begin
					state_q <= S_CHECK;
				end
				S_CHECK: begin
					if (no_cell) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_MOD;
					end
				end
				S_MOD: begin
					if (div_stat.done) begin
						state_q <= S_RD;
					end
				end
				S_RD: begin
					state_q <= S_SWAP1;
				end
				S_SWAP1: begin
					state_q <= S_SWAP2;
				end
				S_SWAP2: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (div_stat.done) begin
						done_q  <= 1'b1;
						used_q  <= used_q + 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			rnd_q <= item.rand_value;
		end
		if (state_q == S_MUL) begin
			prod_q <= rows_q * cols_q;
		end
		if (state_q == S_MOD && div_stat.done) begin
			pick_q <= div_rem[IDX_W-1:0] + used_idx;
		end
		if (state_q == S_CHECK && no_cell) begin
			result_q.row_index <= '0;
			result_q.col_index <= '0;
			result_q.exhausted <= 1'b1;
		end else if (state_q == S_DIV && div_stat.done) begin
			result_q.row_index <= div_quot[COORD_W-1:0];
			result_q.col_index <= div_rem[COORD_W-1:0];
			result_q.exhausted <= 1'b0;
		end
	end

	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(state_q) == S_CHECK || $past(state_q) == S_DIV))
		else $error("result strobe outside a finishing state");

	a_used_range: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= CNT_W'(MAX_CELLS))
		else $error("used count beyond table size");

	a_pick_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_RD |-> (CNT_W'(pick_q) >= used_q && CNT_W'(pick_q) < total))
		else $error("swap index outside the free range");

	a_clear_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CLEAR |-> busy && !done)
		else $error("transaction possible during table clear");

endmodule
